// ===== hw/rtl/utcd_pkg.sv =====
// Shared constants, register codes and the month-length table for the
// UTC to local civil date pipeline. No dependencies.
package utcd_pkg;

	localparam int TIME_BITS_DEF = 40;
	localparam int OUT_W = 40;
	localparam int SEC_PER_DAY = 86400;
	localparam int DST_START_SEC = 10 * 3600;
	localparam int DST_END_SEC = 9 * 3600;

	localparam logic signed [10:0] OFF_DAYLIGHT = -11'sd420;
	localparam logic signed [10:0] OFF_STANDARD = -11'sd480;
	localparam logic signed [10:0] OFF_MIN = -11'sd720;
	localparam logic signed [10:0] OFF_MAX = 11'sd840;
	localparam logic signed [10:0] OFF_RESET = -11'sd480;

	typedef enum logic {
		REG_AUTO  = 1'b0,
		REG_FIXED = 1'b1
	} reg_idx_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2: begin
				n = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				n = 5'd30;
			end
			default: begin
				n = 5'd31;
			end
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/utcd_cdiv.sv =====
// Pipelined restoring divider by a constant, K quotient bits per stage,
// with a sideband that travels alongside. Standalone, no package needed.
module utcd_cdiv #(
	parameter int W  = 34,
	parameter int D  = 675,
	parameter int K  = 8,
	parameter int SW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [W-1:0]         in_num,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [W-1:0]         out_quo,
	output logic [$clog2(D)-1:0] out_rem,
	output logic [SW-1:0]        out_side
);
	localparam int RW = $clog2(D);
	localparam int NS = (W + K - 1) / K;
	localparam int WP = NS * K;
	localparam logic [RW:0] DV = (RW + 1)'(D);

	typedef struct packed {
		logic [RW-1:0] r;
		logic [WP-1:0] a;
	} work_t;

	function automatic work_t step(input work_t w);
		work_t o;
		logic [RW:0] t;
		o = w;
		for (int i = 0; i < K; i++) begin
			t = {o.r, o.a[WP-1]};
			o.a = {o.a[WP-2:0], 1'b0};
			if (t >= DV) begin
				t = t - DV;
				o.a[0] = 1'b1;
			end
			o.r = t[RW-1:0];
		end
		return o;
	endfunction

	work_t       work_s [NS];
	logic [SW-1:0] side_s [NS];
	logic        vld_s  [NS];
	logic [NS:0] rdy;

	assign rdy[NS] = out_ready;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		work_t         prev_w;
		logic          prev_v;
		logic [SW-1:0] prev_side;

		if (j == 0) begin : g_first
			assign prev_w.r = '0;
			assign prev_w.a = WP'(in_num);
			assign prev_v = in_valid;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_w = work_s[j-1];
			assign prev_v = vld_s[j-1];
			assign prev_side = side_s[j-1];
		end

		// stage advances when empty or when the next one takes its word
		assign rdy[j] = !vld_s[j] || rdy[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && prev_v) begin
				work_s[j] <= step(prev_w);
				side_s[j] <= prev_side;
			end
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = vld_s[NS-1];
	assign out_quo = work_s[NS-1].a[W-1:0];
	assign out_rem = work_s[NS-1].r;
	assign out_side = side_s[NS-1];

endmodule

// ===== hw/rtl/utc_to_local_civil_date.sv =====
// Top level: UTC timestamp to local civil date with US Pacific daylight rule.
// Depends on utcd_pkg and utcd_cdiv.
//
// channel  | dir | signals                            | meaning
// s_axis   | in  | s_tvalid s_tready s_tdata          | utc_seconds word
// m_axis   | out | m_tvalid m_tready m_tdata          | offset, year, month, day, weekday
// apb      | in  | psel penable pwrite paddr pwdata   | auto_pacific @0, fixed offset @4
//
// One word enters per cycle unless m_tready stalls the pipeline. Each word
// passes the day divider (by 86400), the era divider (by 146097) and 7 date
// stages. Each stage holds its word while the next stage is full and stalled,
// so a stall on m_tready loses and repeats nothing; empty stages still fill.
// Reset clears the valid bits and loads the register reset values.
module utc_to_local_civil_date #(
	parameter int TIME_BITS = utcd_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [TIME_BITS-1:0] utc_seconds, zero fill above
	input  logic [((TIME_BITS + 7) / 8) * 8-1:0] s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [10:0] offset_minutes, [26:11] local_year, [30:27] local_month,
	// [35:31] local_day, [38:36] local_weekday, [39] zero
	output logic [utcd_pkg::OUT_W-1:0]         m_tdata
);
	import utcd_pkg::*;

	localparam int UW = TIME_BITS + 1;
	localparam int VW = UW - 7;
	localparam longint E_SEC = longint'(146097) * SEC_PER_DAY;
	localparam longint NERA = ((longint'(1) << (TIME_BITS - 1)) + E_SEC - 1) / E_SEC;
	localparam longint BIAS = NERA * E_SEC;
	localparam longint ZMAX = (longint'(1) << UW) / SEC_PER_DAY + 719469;
	localparam int DW = $clog2(ZMAX + 1);
	localparam int WD_OFS = (7 - (719464 % 7)) % 7;
	localparam logic [15:0] YEAR_BIAS = 16'(NERA * 400);

	localparam int S_1460 = 29;
	localparam longint M_1460 = ((longint'(1) << S_1460) + 1459) / 1460;
	localparam int S_36524 = 34;
	localparam longint M_36524 = ((longint'(1) << S_36524) + 36523) / 36524;
	localparam int S_7A = 21;
	localparam longint M_7A = ((longint'(1) << S_7A) + 6) / 7;
	localparam int S_365 = 27;
	localparam longint M_365 = ((longint'(1) << S_365) + 364) / 365;
	localparam int S_100 = 16;
	localparam longint M_100 = ((longint'(1) << S_100) + 99) / 100;
	localparam int S_153 = 19;
	localparam longint M_153 = ((longint'(1) << S_153) + 152) / 153;
	localparam int S_7B = 12;
	localparam longint M_7B = ((longint'(1) << S_7B) + 6) / 7;
	localparam int S_5 = 14;
	localparam longint M_5 = ((longint'(1) << S_5) + 4) / 5;

	// configuration
	logic               auto_q;
	logic signed [10:0] fixed_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q <= 1'b1;
			fixed_q <= OFF_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[2]))
				REG_AUTO: begin
					auto_q <= pwdata[0];
				end
				REG_FIXED: begin
					fixed_q <= pwdata[10:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_AUTO: begin
				prdata = {31'd0, auto_q};
			end
			REG_FIXED: begin
				prdata = {21'd0, fixed_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// bias by whole eras so that both divisions see non-negative operands
	logic [UW-1:0] u_w;
	assign u_w = {s_tdata[TIME_BITS-1], s_tdata[TIME_BITS-1:0]} + UW'(BIAS);

	logic          d1_valid, d1_ready;
	logic [VW-1:0] d1_quo;
	logic [9:0]    d1_rem;
	logic [6:0]    d1_side;

	utcd_cdiv #(.W(VW), .D(675), .K(8), .SW(7)) u_day_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_num   (u_w[UW-1:7]),
		.in_side  (u_w[6:0]),
		.out_valid(d1_valid),
		.out_ready(d1_ready),
		.out_quo  (d1_quo),
		.out_rem  (d1_rem),
		.out_side (d1_side)
	);

	logic [DW-1:0] z_w;
	assign z_w = DW'(d1_quo) + DW'(719468);

	logic          d2_valid;
	logic [DW-1:0] d2_quo;
	logic [17:0]   d2_rem;
	logic [16:0]   d2_side;
	logic          rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9;

	utcd_cdiv #(.W(DW), .D(146097), .K(8), .SW(17)) u_era_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d1_valid),
		.in_ready (d1_ready),
		.in_num   (z_w),
		.in_side  ({d1_rem, d1_side}),
		.out_valid(d2_valid),
		.out_ready(rdy3),
		.out_quo  (d2_quo),
		.out_rem  (d2_rem),
		.out_side (d2_side)
	);

	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	assign rdy9 = !vld_s9 || m_tready;
	assign rdy8 = !vld_s8 || rdy9;
	assign rdy7 = !vld_s7 || rdy8;
	assign rdy6 = !vld_s6 || rdy7;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (rdy3) vld_s3 <= d2_valid;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
			if (rdy8) vld_s8 <= vld_s7;
			if (rdy9) vld_s9 <= vld_s8;
		end
	end

	// stage 3: century terms, weekday, era year
	logic [39:0] p_1460, p_36524, p_7a;
	logic [17:0] wx_w;
	logic [14:0] q7_w;
	logic [17:0] doe_s3;
	logic [15:0] era400_s3;
	logic [16:0] sod_s3;
	logic [6:0]  a1_s3;
	logic [2:0]  a2_s3, wd_s3;
	logic        a3_s3;

	assign p_1460 = 40'(d2_rem) * 40'(M_1460);
	assign p_36524 = 40'(d2_rem) * 40'(M_36524);
	assign wx_w = d2_rem + 18'(WD_OFS);
	assign p_7a = 40'(wx_w) * 40'(M_7A);
	assign q7_w = 15'(p_7a >> S_7A);

	always_ff @(posedge clk) begin
		if (rdy3 && d2_valid) begin
			doe_s3 <= d2_rem;
			sod_s3 <= d2_side;
			a1_s3 <= 7'(p_1460 >> S_1460);
			a2_s3 <= 3'(p_36524 >> S_36524);
			a3_s3 <= (d2_rem == 18'd146096);
			wd_s3 <= 3'(wx_w - 18'(q7_w) * 18'd7);
			era400_s3 <= 16'(d2_quo) * 16'd400 - YEAR_BIAS;
		end
	end

	// stage 4: year of era
	logic [17:0] t_w;
	logic [39:0] p_365;
	logic [17:0] doe_s4;
	logic [15:0] era400_s4;
	logic [16:0] sod_s4;
	logic [8:0]  yoe_s4;
	logic [2:0]  wd_s4;

	assign t_w = doe_s3 - 18'(a1_s3) + 18'(a2_s3) - 18'(a3_s3);
	assign p_365 = 40'(t_w) * 40'(M_365);

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			yoe_s4 <= 9'(p_365 >> S_365);
			doe_s4 <= doe_s3;
			era400_s4 <= era400_s3;
			sod_s4 <= sod_s3;
			wd_s4 <= wd_s3;
		end
	end

	// stage 5: day of March-based year
	logic [19:0] p_100;
	logic [17:0] nd_w;
	logic [8:0]  doy_s5, yoe_s5;
	logic [15:0] era400_s5;
	logic [16:0] sod_s5;
	logic [2:0]  wd_s5;

	assign p_100 = 20'(yoe_s4) * 20'(M_100);
	assign nd_w = 18'(yoe_s4) * 18'd365 + 18'(yoe_s4[8:2]) - 18'(p_100 >> S_100);

	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			doy_s5 <= 9'(doe_s4 - nd_w);
			yoe_s5 <= yoe_s4;
			era400_s5 <= era400_s4;
			sod_s5 <= sod_s4;
			wd_s5 <= wd_s4;
		end
	end

	// stage 6: month index and day-of-year mod 7
	logic [10:0] x5_w;
	logic [23:0] p_153, p_7b;
	logic [5:0]  q7b_w;
	logic [3:0]  mp_s6;
	logic [2:0]  dm7_s6, wd_s6;
	logic [8:0]  doy_s6, yoe_s6;
	logic [15:0] era400_s6;
	logic [16:0] sod_s6;

	assign x5_w = 11'(doy_s5) * 11'd5 + 11'd2;
	assign p_153 = 24'(x5_w) * 24'(M_153);
	assign p_7b = 24'(doy_s5) * 24'(M_7B);
	assign q7b_w = 6'(p_7b >> S_7B);

	always_ff @(posedge clk) begin
		if (rdy6 && vld_s5) begin
			mp_s6 <= 4'(p_153 >> S_153);
			dm7_s6 <= 3'(doy_s5 - 9'(q7b_w) * 9'd7);
			doy_s6 <= doy_s5;
			yoe_s6 <= yoe_s5;
			era400_s6 <= era400_s5;
			sod_s6 <= sod_s5;
			wd_s6 <= wd_s5;
		end
	end

	// stage 7: month, day, year, leap flag, daylight window
	logic        jan_feb_w, leap_w, dst_w;
	logic [3:0]  mm_w, diff_w;
	logic [10:0] x153_w;
	logic [23:0] p_5;
	logic [8:0]  ds_w, ymod_w, start_w, end_w;
	logic [2:0]  wdm_w, delta_w;
	logic [15:0] year_s7;
	logic [3:0]  mm_s7;
	logic [4:0]  day_s7;
	logic        leap_s7, dst_s7;
	logic [2:0]  wd_s7;
	logic [16:0] sod_s7;

	assign jan_feb_w = (mp_s6 >= 4'd10);
	assign mm_w = jan_feb_w ? mp_s6 - 4'd9 : mp_s6 + 4'd3;
	assign x153_w = 11'(mp_s6) * 11'd153 + 11'd2;
	assign p_5 = 24'(x153_w) * 24'(M_5);
	assign ds_w = 9'(p_5 >> S_5);
	assign ymod_w = jan_feb_w ? ((yoe_s6 == 9'd399) ? 9'd0 : yoe_s6 + 9'd1) : yoe_s6;
	assign leap_w = (ymod_w[1:0] == 2'b00) && !(ymod_w inside {9'd100, 9'd200, 9'd300});
	// weekday of March 1 of this year; November 1 falls on the same weekday
	assign diff_w = {1'b0, wd_s6} - {1'b0, dm7_s6};
	assign wdm_w = diff_w[3] ? 3'(diff_w + 4'd7) : diff_w[2:0];
	assign delta_w = (wdm_w == 3'd0) ? 3'd0 : 3'(4'd7 - {1'b0, wdm_w});
	assign start_w = 9'(delta_w) + 9'd7;
	assign end_w = 9'd245 + 9'(delta_w);
	assign dst_w = ((doy_s6 > start_w) ||
			((doy_s6 == start_w) && (sod_s6 >= 17'(DST_START_SEC)))) &&
		((doy_s6 < end_w) ||
			((doy_s6 == end_w) && (sod_s6 < 17'(DST_END_SEC))));

	always_ff @(posedge clk) begin
		if (rdy7 && vld_s6) begin
			year_s7 <= era400_s6 + 16'(yoe_s6) + 16'(jan_feb_w);
			mm_s7 <= mm_w;
			day_s7 <= 5'(doy_s6 - ds_w + 9'd1);
			leap_s7 <= leap_w;
			dst_s7 <= dst_w;
			wd_s7 <= wd_s6;
			sod_s7 <= sod_s6;
		end
	end

	// stage 8: pick the offset and find the local day shift
	logic signed [10:0] off_w;
	logic signed [18:0] lsod_w;
	logic signed [10:0] off_s8;
	logic [15:0]        year_s8;
	logic [3:0]         mm_s8;
	logic [4:0]         day_s8;
	logic               leap_s8, inc_s8, dec_s8;
	logic [2:0]         wd_s8;

	always_comb begin
		if (auto_q) begin
			off_w = dst_s7 ? OFF_DAYLIGHT : OFF_STANDARD;
		end else if (fixed_q < OFF_MIN) begin
			off_w = OFF_MIN;
		end else if (fixed_q > OFF_MAX) begin
			off_w = OFF_MAX;
		end else begin
			off_w = fixed_q;
		end
	end

	assign lsod_w = $signed({2'b00, sod_s7}) + 19'(off_w) * 19'sd60;

	always_ff @(posedge clk) begin
		if (rdy8 && vld_s7) begin
			off_s8 <= off_w;
			inc_s8 <= (lsod_w >= 19'sd86400);
			dec_s8 <= lsod_w[18];
			year_s8 <= year_s7;
			mm_s8 <= mm_s7;
			day_s8 <= day_s7;
			leap_s8 <= leap_s7;
			wd_s8 <= wd_s7;
		end
	end

	// stage 9: step the date one day forward or back, output register
	logic [4:0]         ml_w, pml_w;
	logic [3:0]         pm_w;
	logic [15:0]        year_n;
	logic [3:0]         mm_n;
	logic [4:0]         day_n;
	logic [2:0]         wd_n;
	logic signed [10:0] off_s9;
	logic [15:0]        year_s9;
	logic [3:0]         mm_s9;
	logic [4:0]         day_s9;
	logic [2:0]         wd_s9;

	assign ml_w = month_len(mm_s8, leap_s8);
	assign pm_w = (mm_s8 == 4'd1) ? 4'd12 : mm_s8 - 4'd1;
	assign pml_w = month_len(pm_w, leap_s8);

	always_comb begin
		year_n = year_s8;
		mm_n = mm_s8;
		day_n = day_s8;
		wd_n = wd_s8;
		if (inc_s8) begin
			wd_n = (wd_s8 == 3'd6) ? 3'd0 : wd_s8 + 3'd1;
			if (day_s8 == ml_w) begin
				day_n = 5'd1;
				if (mm_s8 == 4'd12) begin
					mm_n = 4'd1;
					year_n = year_s8 + 16'd1;
				end else begin
					mm_n = mm_s8 + 4'd1;
				end
			end else begin
				day_n = day_s8 + 5'd1;
			end
		end else if (dec_s8) begin
			wd_n = (wd_s8 == 3'd0) ? 3'd6 : wd_s8 - 3'd1;
			if (day_s8 == 5'd1) begin
				mm_n = pm_w;
				day_n = pml_w;
				if (mm_s8 == 4'd1) begin
					year_n = year_s8 - 16'd1;
				end
			end else begin
				day_n = day_s8 - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy9 && vld_s8) begin
			off_s9 <= off_s8;
			year_s9 <= year_n;
			mm_s9 <= mm_n;
			day_s9 <= day_n;
			wd_s9 <= wd_n;
		end
	end

	assign m_tvalid = vld_s9;
	assign m_tdata = {1'b0, wd_s9, day_s9, mm_s9, year_s9, off_s9};

endmodule

// ===== hw/rtl/utcd_checker.sv =====
// Port-level checks for utc_to_local_civil_date, bound to the top level.
// Depends on utcd_pkg.
module utcd_checker #(
	parameter int TIME_BITS = utcd_pkg::TIME_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [utcd_pkg::OUT_W-1:0] m_tdata
);
	import utcd_pkg::*;

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	// an empty output register means every stage can take a word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[30:27] >= 4'd1) && (m_tdata[30:27] <= 4'd12) &&
			(m_tdata[35:31] >= 5'd1) && (m_tdata[38:36] <= 3'd6) && !m_tdata[39])
		else $error("date field out of range");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[10:0]) >= OFF_MIN) &&
			($signed(m_tdata[10:0]) <= OFF_MAX))
		else $error("offset out of range");

endmodule

bind utc_to_local_civil_date utcd_checker #(.TIME_BITS(TIME_BITS)) u_utcd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
